@@ design/bulsol_pkg.sv @@
package bulsol_pkg;

    localparam int DATA_W   = 32;
    localparam int NUM_COEF = 8;
    localparam int BW_W     = 4;
    localparam logic [BW_W-1:0] BAND_WIDTH_RESET = 4'd8;

    typedef struct packed {
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] coef_back_1;
        logic signed [DATA_W-1:0] coef_back_2;
        logic signed [DATA_W-1:0] coef_back_3;
        logic signed [DATA_W-1:0] coef_back_4;
        logic signed [DATA_W-1:0] coef_back_5;
        logic signed [DATA_W-1:0] coef_back_6;
        logic signed [DATA_W-1:0] coef_back_7;
        logic signed [DATA_W-1:0] coef_back_8;
        logic                     first_row;
        logic                     last_row;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] solution;
        logic                     overflow;
        logic                     final_row;
    } out_t;

    // Strobes from the sequencer to every cell of the chain.
    typedef struct packed {
        logic load;
        logic clear;
        logic mult;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_SUM,
        ST_FINAL
    } state_t;

endpackage

@@ design/bulsol_cell.sv @@
module bulsol_cell #(
    parameter int SUM_W = 68
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  bulsol_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [bulsol_pkg::DATA_W-1:0]   coef,
    input  logic                                   en,
    input  logic signed [bulsol_pkg::DATA_W-1:0]   hist_in,
    output logic signed [bulsol_pkg::DATA_W-1:0]   hist_out,
    input  logic signed [SUM_W-1:0]                sum_in,
    output logic signed [SUM_W-1:0]                sum_out
);

    localparam int PROD_W = 2 * bulsol_pkg::DATA_W;

    logic signed [bulsol_pkg::DATA_W-1:0] coef_reg;
    logic                                 en_reg;
    logic signed [bulsol_pkg::DATA_W-1:0] hist_reg;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [PROD_W-1:0]             prod_next;
    logic signed [SUM_W-1:0]              sum_reg;
    logic signed [SUM_W-1:0]              sum_next;

    assign prod_next = coef_reg * hist_reg;

    // The partial sum moves one cell toward the head every cycle; once the
    // products are steady and their sums have rippled through every cell, the
    // head holds the whole band sum.
    assign sum_next = sum_in + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (ctrl.clear) begin
            hist_reg <= '0;
        end else if (ctrl.shift) begin
            hist_reg <= hist_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            coef_reg <= coef;
            en_reg   <= en;
        end
        if (ctrl.mult) begin
            prod_reg <= en_reg ? prod_next : '0;
        end
        sum_reg <= sum_next;
    end

    assign hist_out = hist_reg;
    assign sum_out  = sum_reg;

endmodule

@@ design/banded_unit_lower_solve.sv @@
// Forward substitution for a unit lower triangular banded system, one row per
// transfer. Each row brings its right-hand side and up to eight sub-diagonal
// coefficients; the solution x = rhs - sum(coef_k * x[row-k]) is computed
// exactly, shifted back to Q format with truncation toward minus infinity and
// saturated to 32 bits, with overflow flagged. A chain of BAND_MAX cells holds
// the solution history, one entry per cell, and each cell owns one multiplier;
// the band sum ripples through the chain one cell per cycle. A row goes
// through its steps in order and the next row is accepted after the last:
// accept, multiply, the sum chain, then saturate and shift the history, which
// waits while the output register holds an unread result. The result sits in
// an output register, so the next row is accepted while it waits. Set first_row
// to clear the history; band_width limits how many coefficients are used.
module banded_unit_lower_solve #(
    parameter int BAND_MAX  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bulsol_pkg::in_t                     s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bulsol_pkg::out_t                    m_data,
    input  logic                                cfg_wen,
    input  logic [bulsol_pkg::BW_W-1:0]         cfg_wdata
);

    localparam int DW       = bulsol_pkg::DATA_W;
    localparam int SUM_W    = 2 * DW + $clog2(BAND_MAX) + 1;
    localparam int ACC_W    = SUM_W + 1;
    localparam int USED_MAX = (BAND_MAX < bulsol_pkg::NUM_COEF) ? BAND_MAX
                                                                : bulsol_pkg::NUM_COEF;
    localparam int CNT_W    = (BAND_MAX > 1) ? $clog2(BAND_MAX) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BAND_MAX - 1);

    bulsol_pkg::state_t       state_reg, state_next;
    bulsol_pkg::cell_ctrl_t   ctrl;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bulsol_pkg::BW_W-1:0] bw_reg;
    logic signed [DW-1:0]     rhs_reg;
    logic                     last_reg;
    logic                     out_load;
    logic                     m_valid_reg;
    bulsol_pkg::out_t         m_data_reg;

    logic signed [DW-1:0]     coef_arr [bulsol_pkg::NUM_COEF];
    logic signed [DW-1:0]     hist_w   [BAND_MAX];
    logic signed [SUM_W-1:0]  sum_w    [BAND_MAX];

    logic signed [ACC_W-1:0]  rhs_ext;
    logic signed [ACC_W-1:0]  sum_ext;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_sh;
    logic                     fits;
    logic signed [DW-1:0]     res;
    logic                     ovf;

    always_comb begin
        coef_arr[0] = s_data.coef_back_1;
        coef_arr[1] = s_data.coef_back_2;
        coef_arr[2] = s_data.coef_back_3;
        coef_arr[3] = s_data.coef_back_4;
        coef_arr[4] = s_data.coef_back_5;
        coef_arr[5] = s_data.coef_back_6;
        coef_arr[6] = s_data.coef_back_7;
        coef_arr[7] = s_data.coef_back_8;
    end

    for (genvar i = 0; i < BAND_MAX; i++) begin : g_cell
        logic signed [DW-1:0]    cell_coef;
        logic                    cell_en;
        logic signed [DW-1:0]    cell_hist_in;
        logic signed [SUM_W-1:0] cell_sum_in;

        if (i < USED_MAX) begin : g_used
            assign cell_coef = coef_arr[i];
            assign cell_en   = (5'(i) < {1'b0, bw_reg});
        end else begin : g_unused
            assign cell_coef = '0;
            assign cell_en   = 1'b0;
        end

        if (i == 0) begin : g_head
            assign cell_hist_in = res;
        end else begin : g_body
            assign cell_hist_in = hist_w[i-1];
        end

        if (i == BAND_MAX - 1) begin : g_tail
            assign cell_sum_in = '0;
        end else begin : g_mid
            assign cell_sum_in = sum_w[i+1];
        end

        bulsol_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .coef     (cell_coef),
            .en       (cell_en),
            .hist_in  (cell_hist_in),
            .hist_out (hist_w[i]),
            .sum_in   (cell_sum_in),
            .sum_out  (sum_w[i])
        );
    end

    // Exact accumulation, then arithmetic shift back to Q format and saturation.
    always_comb begin
        rhs_ext = {{(ACC_W-DW){rhs_reg[DW-1]}}, rhs_reg};
        sum_ext = {sum_w[0][SUM_W-1], sum_w[0]};
        acc     = (rhs_ext <<< FRAC_BITS) - sum_ext;
        acc_sh  = acc >>> FRAC_BITS;
        fits    = (&acc_sh[ACC_W-1:DW-1]) | ~(|acc_sh[ACC_W-1:DW-1]);
        ovf     = ~fits;
        if (fits) begin
            res = acc_sh[DW-1:0];
        end else if (acc_sh[ACC_W-1]) begin
            res = {1'b1, {(DW-1){1'b0}}};
        end else begin
            res = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            bulsol_pkg::ST_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    ctrl.clear = s_data.first_row;
                    state_next = bulsol_pkg::ST_MULT;
                end
            end
            bulsol_pkg::ST_MULT: begin
                ctrl.mult  = 1'b1;
                cnt_next   = '0;
                state_next = bulsol_pkg::ST_SUM;
            end
            bulsol_pkg::ST_SUM: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = bulsol_pkg::ST_FINAL;
                end
            end
            bulsol_pkg::ST_FINAL: begin
                if (!m_valid_reg || m_ready) begin
                    ctrl.shift = 1'b1;
                    out_load   = 1'b1;
                    state_next = bulsol_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bulsol_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bulsol_pkg::ST_IDLE;
            cnt_reg     <= '0;
            bw_reg      <= bulsol_pkg::BAND_WIDTH_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen) begin
                bw_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rhs_reg  <= s_data.rhs;
            last_reg <= s_data.last_row;
        end
        if (out_load) begin
            m_data_reg.solution  <= res;
            m_data_reg.overflow  <= ovf;
            m_data_reg.final_row <= last_reg;
        end
    end

    assign s_ready = (state_reg == bulsol_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ verif/tb_banded_unit_lower_solve.sv @@
module tb_banded_unit_lower_solve;

    import bulsol_pkg::*;

    localparam int BAND_MAX       = 8;
    localparam int FRAC_BITS      = 16;
    localparam int DIR_ROWS       = 22;
    localparam int NUM_PHASES     = 12;
    localparam int ROWS_PER_PHASE = 125;
    localparam int HOLD_CYCLES    = 400;

    localparam logic [31:0] ZERO = 32'h0000_0000;
    localparam logic [31:0] LSB  = 32'h0000_0001;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] NEG1 = 32'hFFFF_0000;
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] QMIN = 32'h8000_0000;

    localparam logic signed [71:0] SOL_MAX = 72'sh7FFF_FFFF;
    localparam logic signed [71:0] SOL_MIN = -72'sh8000_0000;

    typedef struct packed {
        logic [31:0]      rhs;
        logic [0:7][31:0] coef;
        logic             first;
        logic             last;
        logic             typed;
        logic [31:0]      want_sol;
        logic             want_ovf;
    } dir_row_t;

    // Rows with typed results are the ones whose answer is plain: cleared history,
    // zero coefficients, a single unit product, or a sum far outside the Q16.16 range.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{ONE,          {8{QMIN}},                1'b1, 1'b0, 1'b1, ONE,  1'b0},
        '{ZERO,         {ONE, {7{ZERO}}},         1'b0, 1'b0, 1'b1, NEG1, 1'b0},
        '{ONE,          {ONE, ONE, {6{ZERO}}},    1'b0, 1'b0, 1'b0, ZERO, 1'b0},
        '{LSB,          {8{ZERO}},                1'b1, 1'b0, 1'b1, LSB,  1'b0},
        '{ZERO,         {LSB, {7{ZERO}}},         1'b0, 1'b0, 1'b0, ZERO, 1'b0},
        '{ZERO,         {8{QMIN}},                1'b0, 1'b0, 1'b0, ZERO, 1'b0},
        '{QMAX,         {8{QMAX}},                1'b1, 1'b0, 1'b1, QMAX, 1'b0},
        '{QMIN,         {QMAX, {7{ZERO}}},        1'b0, 1'b0, 1'b1, QMIN, 1'b1},
        '{QMAX,         {QMAX, {7{ZERO}}},        1'b0, 1'b0, 1'b1, QMAX, 1'b1},
        '{ZERO,         {8{QMIN}},                1'b0, 1'b1, 1'b0, ZERO, 1'b0},
        '{ONE,          {8{ONE}},                 1'b0, 1'b0, 1'b0, ZERO, 1'b0},
        '{QMIN,         {8{QMIN}},                1'b1, 1'b1, 1'b1, QMIN, 1'b0},
        '{32'h0003_0000, {8{NEG1}},               1'b1, 1'b0, 1'b1, 32'h0003_0000, 1'b0},
        '{32'h0004_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0004_0000, 1'b0},
        '{32'h0005_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0005_0000, 1'b0},
        '{32'h0006_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0006_0000, 1'b0},
        '{32'h0007_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0007_0000, 1'b0},
        '{32'h0008_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0008_0000, 1'b0},
        '{32'h0009_0000, {8{ZERO}},               1'b0, 1'b0, 1'b1, 32'h0009_0000, 1'b0},
        '{32'h000A_0000, {8{ONE}},                1'b0, 1'b0, 1'b0, ZERO, 1'b0},
        '{ZERO,         {8{QMIN}},                1'b0, 1'b1, 1'b0, ZERO, 1'b0},
        '{32'hFFFF_FFFF, {8{32'h0000_8000}},      1'b0, 1'b0, 1'b0, ZERO, 1'b0}
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_t                 s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_t                m_data;
    logic                cfg_wen   = 1'b0;
    logic [BW_W-1:0]     cfg_wdata = '0;

    logic [BW_W-1:0]     band_width_model = BAND_WIDTH_RESET;
    logic signed [31:0]  sol_hist [NUM_COEF] = '{default: '0};
    out_t                expected_solutions [$];

    bit                  hold_req  = 1'b0;
    bit                  hold_done = 1'b0;
    bit                  quiet     = 1'b0;
    int unsigned         failures  = 0;
    int unsigned         rows_sent = 0;
    int unsigned         systems   = 0;
    int unsigned         checked   = 0;
    int unsigned         saturated = 0;

    banded_unit_lower_solve #(
        .BAND_MAX  (BAND_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Exact forward-substitution step; updates the solution history like the block does.
    function automatic out_t solve_row(input in_t row);
        logic signed [31:0] coefs [NUM_COEF];
        logic signed [71:0] acc;
        logic signed [71:0] q;
        int                 used;
        out_t               r;
        coefs = '{row.coef_back_1, row.coef_back_2, row.coef_back_3, row.coef_back_4,
                  row.coef_back_5, row.coef_back_6, row.coef_back_7, row.coef_back_8};
        used = int'(band_width_model);
        if (used > BAND_MAX) used = BAND_MAX;
        if (used > NUM_COEF) used = NUM_COEF;
        if (row.first_row) begin
            foreach (sol_hist[k]) sol_hist[k] = '0;
        end
        acc = $signed(row.rhs);
        acc = acc <<< FRAC_BITS;
        for (int k = 0; k < used; k++) begin
            acc = acc - ($signed(coefs[k]) * $signed(sol_hist[k]));
        end
        q = acc >>> FRAC_BITS;
        r.final_row = row.last_row;
        if (q > SOL_MAX) begin
            r.solution = QMAX;
            r.overflow = 1'b1;
        end else if (q < SOL_MIN) begin
            r.solution = QMIN;
            r.overflow = 1'b1;
        end else begin
            r.solution = q[31:0];
            r.overflow = 1'b0;
        end
        for (int k = NUM_COEF - 1; k > 0; k--) begin
            sol_hist[k] = sol_hist[k - 1];
        end
        sol_hist[0] = r.solution;
        return r;
    endfunction

    function automatic in_t to_row(input logic [31:0] rhs, input logic [0:7][31:0] coef,
                                   input logic first, input logic last);
        in_t row;
        row.rhs         = rhs;
        row.coef_back_1 = coef[0];
        row.coef_back_2 = coef[1];
        row.coef_back_3 = coef[2];
        row.coef_back_4 = coef[3];
        row.coef_back_5 = coef[4];
        row.coef_back_6 = coef[5];
        row.coef_back_7 = coef[6];
        row.coef_back_8 = coef[7];
        row.first_row   = first;
        row.last_row    = last;
        return row;
    endfunction

    // Mostly narrow values so the recurrence stays in range; some full-width and corner values.
    function automatic logic [31:0] rand_q(input bit is_rhs);
        logic [31:0] v;
        int unsigned sel;
        int          w;
        v   = $urandom;
        sel = $urandom_range(0, 9);
        if (sel == 9) begin
            case ($urandom_range(0, 4))
                0: return QMAX;
                1: return QMIN;
                2: return ZERO;
                3: return ONE;
                default: return NEG1;
            endcase
        end
        if (sel == 8) return v;
        if (sel >= 6) w = is_rhs ? 24 : 17;
        else w = is_rhs ? 20 : 13;
        return 32'($signed(v << (32 - w)) >>> (32 - w));
    endfunction

    task automatic offer_row(input in_t row, input logic typed, input out_t want);
        out_t pred;
        s_data  <= row;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred = solve_row(row);
        expected_solutions.push_back(typed ? want : pred);
        rows_sent++;
        if (row.first_row) systems++;
    endtask

    task automatic set_band_width(input logic [BW_W-1:0] bw);
        while (expected_solutions.size() != 0) @(posedge aclk);
        repeat (BAND_MAX + 3) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= bw;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        band_width_model = bw;
    endtask

    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_solutions.size() == 0) begin
                $error("result transfer with nothing expected: solution %h", m_data.solution);
                failures++;
            end else begin
                want = expected_solutions.pop_front();
                checked++;
                if (want.overflow) saturated++;
                if (m_data.solution !== want.solution) begin
                    $error("solution: expected %h, actual %h", want.solution, m_data.solution);
                    failures++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $error("overflow: expected %b, actual %b", want.overflow, m_data.overflow);
                    failures++;
                end
                if (m_data.final_row !== want.final_row) begin
                    $error("final_row: expected %b, actual %b", want.final_row,
                           m_data.final_row);
                    failures++;
                end
            end
        end
    end

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned cyc;
        bit          rx_idle_on;
        stall_left = 0;
        cyc        = 0;
        rx_idle_on = 1'b1;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (cyc % 256 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                // Long hold-off so the output register fills and the input side stalls.
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            cyc++;
            @(posedge aclk);
        end
    end

    initial begin : row_source
        logic [BW_W-1:0]  phase_bw [NUM_PHASES];
        logic [0:7][31:0] coef;
        in_t              row;
        out_t             want;
        int               n;
        int               sys_len;
        bit               cont;
        bit               tx_idle_on;
        phase_bw   = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd9, 4'd3, 4'd6, 4'd2, 4'd7, 4'd5, 4'd4, 4'd8};
        tx_idle_on = 1'b1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            row = to_row(dir_tab[i].rhs, dir_tab[i].coef, dir_tab[i].first, dir_tab[i].last);
            want.solution  = dir_tab[i].want_sol;
            want.overflow  = dir_tab[i].want_ovf;
            want.final_row = dir_tab[i].last;
            offer_row(row, dir_tab[i].typed, want);
        end
        s_valid <= 1'b0;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_band_width(phase_bw[ph]);
            quiet = (ph == NUM_PHASES - 1);
            n = 0;
            while (n < ROWS_PER_PHASE) begin
                sys_len = $urandom_range(1, 24);
                // Now and then a system simply continues the previous one's history.
                cont = ($urandom_range(0, 9) == 0);
                for (int r = 0; r < sys_len && n < ROWS_PER_PHASE; r++) begin
                    for (int k = 0; k < 8; k++) coef[k] = rand_q(1'b0);
                    row = to_row(rand_q(1'b1), coef,
                                 ((r == 0) && !cont) || ($urandom_range(0, 49) == 0),
                                 (r == sys_len - 1) ^ ($urandom_range(0, 49) == 0));
                    if (ph == 0 && n == 20) hold_req = 1'b1;
                    if (!quiet && tx_idle_on && $urandom_range(0, 3) == 0) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(1, 10)) @(posedge aclk);
                    end
                    offer_row(row, 1'b0, '0);
                    n++;
                end
                tx_idle_on = ($urandom_range(0, 2) != 0);
            end
            s_valid <= 1'b0;
        end

        while (expected_solutions.size() != 0) @(posedge aclk);
        repeat (4 * (BAND_MAX + 3)) @(posedge aclk);

        $display("Solved %0d rows in %0d systems across band widths 0 to 15.", rows_sent,
                 systems);
        $display("Checked %0d results, %0d of them saturated, with one long output stall.",
                 checked, saturated);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ banded_unit_lower_solve.f @@
design/bulsol_pkg.sv
design/bulsol_cell.sv
design/banded_unit_lower_solve.sv
verif/tb_banded_unit_lower_solve.sv
